>>> design/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared constants, types and register codes of the spectral subtraction
// gain block.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Bin store depth and derived widths
  localparam int MaxBins  = 512;
  localparam int BinW     = $clog2(MaxBins);
  localparam int CntW     = BinW + 1;

  // Field and register widths
  localparam int SampleW   = 16;
  localparam int PowerW    = 31;
  localparam int GainW     = 9;
  localparam int QShift    = 9;
  localparam int MeanShift = 1;
  localparam int SmoothSh  = 3;
  localparam int FrameBinW = 10;
  localparam int FactorW   = 15;
  localparam int WindowW   = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int ProdW     = FactorW + PowerW;
  localparam int DivCntW   = $clog2(GainW + 1);

  localparam logic [PowerW-1:0] PowerMax = {PowerW{1'b1}};

  // Register reset values
  localparam logic [FrameBinW-1:0] FrameBinsRst = FrameBinW'(256);
  localparam logic [FactorW-1:0]   OverSubRst   = FactorW'(512);
  localparam logic [FactorW-1:0]   FloorRst     = '0;
  localparam logic [WindowW-1:0]   WindowRst    = WindowW'(20);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameBins = 2'd0,
    CfgOverSub   = 2'd1,
    CfgGainFloor = 2'd2,
    CfgWindow    = 2'd3
  } cfg_idx_e;

  // Item entering the bin store stage
  typedef struct packed {
    logic [BinW-1:0]   idx;
    logic              last;
    logic              restart;
    logic [PowerW-1:0] power;
  } ssg_item_t;

  // Item leaving the bin store stage with its updated noise estimate
  typedef struct packed {
    logic [BinW-1:0]   idx;
    logic              last;
    logic [PowerW-1:0] power;
    logic [PowerW-1:0] noise;
  } ssg_upd_t;

  // Divider request
  typedef struct packed {
    logic [PowerW-1:0] num;
    logic [PowerW:0]   den;
    logic              zero;
    logic [PowerW-1:0] noise;
    logic [BinW-1:0]   idx;
    logic              last;
  } ssg_div_req_t;

  // Divider result
  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [PowerW-1:0] noise;
    logic [BinW-1:0]   idx;
    logic              last;
  } ssg_div_rsp_t;

endpackage

>>> design/ssg_bin_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_bin_store
// Per-bin minimum and noise memory with read-modify-write update of the
// minimum tracker and the smoothed noise estimate.
// ----------------------------------------------------------------------------
module ssg_bin_store
  import ssg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      acc_i,
  input  ssg_item_t item_i,
  input  logic      adv_i,
  output ssg_upd_t  upd_o
);

  localparam int EntryW = 2 * PowerW;

  logic [EntryW-1:0] mem_q [MaxBins];
  logic [EntryW-1:0] rd_data_q;
  ssg_item_t         item_q;
  logic              written_q;
  logic [CntW-1:0]   fill_q, fill_d;

  logic              fwd_valid_q;
  logic [BinW-1:0]   fwd_idx_q;
  logic [PowerW-1:0] fwd_min_q, fwd_noise_q;

  logic [PowerW-1:0] cur_min, cur_noise, new_min, new_noise, blended;
  logic [PowerW:0]   mean_sum, noise_sum;
  logic              fwd_hit;

  // Track how many leading entries have been written since reset
  always_comb begin
    fill_d = fill_q;
    if (acc_i && ({1'b0, item_i.idx} == fill_q)) begin
      fill_d = fill_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Capture the item and whether its entry holds data
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      item_q    <= item_i;
      written_q <= ({1'b0, item_i.idx} < fill_q);
    end
  end

  // Memory: read at accept, write back when the item leaves this stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mem_q[item_q.idx] <= {new_min, new_noise};
    end
    if (acc_i) begin
      rd_data_q <= mem_q[item_i.idx];
    end
  end

  // Hold the last write for a read that raced it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (adv_i) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_idx_q   <= item_q.idx;
      fwd_min_q   <= new_min;
      fwd_noise_q <= new_noise;
    end
  end

  // Select current entry, update minimum and noise
  always_comb begin
    fwd_hit = fwd_valid_q && (fwd_idx_q == item_q.idx);
    if (fwd_hit) begin
      cur_min   = fwd_min_q;
      cur_noise = fwd_noise_q;
    end else if (written_q) begin
      cur_min   = rd_data_q[EntryW-1:PowerW];
      cur_noise = rd_data_q[PowerW-1:0];
    end else begin
      cur_min   = item_q.power;
      cur_noise = '0;
    end

    if (item_q.restart || (item_q.power < cur_min)) begin
      new_min = item_q.power;
    end else begin
      new_min = cur_min;
    end

    mean_sum  = {1'b0, new_min} + {1'b0, cur_noise};
    blended   = mean_sum[PowerW:MeanShift];
    noise_sum = {1'b0, cur_noise} - {{(SmoothSh+1){1'b0}}, cur_noise[PowerW-1:SmoothSh]}
              + {{(SmoothSh+1){1'b0}}, blended[PowerW-1:SmoothSh]};
    new_noise = noise_sum[PowerW-1:0];
  end

  assign upd_o.idx   = item_q.idx;
  assign upd_o.last  = item_q.last;
  assign upd_o.power = item_q.power;
  assign upd_o.noise = new_noise;

endmodule

>>> design/ssg_gain_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_gain_div
// Restoring divider producing the Q0.9 gain one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssg_gain_div
  import ssg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  ssg_div_req_t req_i,
  input  logic         take_i,
  output logic         busy_o,
  output logic         done_o,
  output ssg_div_rsp_t rsp_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [PowerW:0]    rem_q, den_q;
  logic [GainW-1:0]   quo_q;
  logic               zero_q;
  logic [PowerW-1:0]  noise_q;
  logic [BinW-1:0]    idx_q;
  logic               last_q;

  logic [PowerW+1:0]  rem_sh, rem_sub;
  logic               ge;

  // One quotient bit: shift, compare, subtract
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(GainW);
    end else if (busy_q && (cnt_q != '0)) begin
      cnt_q <= cnt_q - DivCntW'(1);
    end else if (take_i) begin
      busy_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q   <= {1'b0, req_i.num};
      den_q   <= req_i.den;
      quo_q   <= '0;
      zero_q  <= req_i.zero;
      noise_q <= req_i.noise;
      idx_q   <= req_i.idx;
      last_q  <= req_i.last;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? rem_sub[PowerW:0] : rem_sh[PowerW:0];
      quo_q <= {quo_q[GainW-2:0], ge};
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = busy_q && (cnt_q == '0);
  assign rsp_o.gain  = zero_q ? '0 : quo_q;
  assign rsp_o.noise = noise_q;
  assign rsp_o.idx   = idx_q;
  assign rsp_o.last  = last_q;

endmodule

>>> design/spectral_subtraction_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_subtraction_gain
// Per-bin noise estimation by minimum tracking and spectral subtraction gain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) transfers one FFT bin per item as
//   bin_real_i / bin_imag_i. Output channel (out_valid_o / out_stall_i)
//   transfers one result per item: gain, updated noise, bin number and the
//   frame end flag. Bins are numbered in arrival order within each frame.
//   Configuration writes go over cfg_valid_i / cfg_ready_o with a register
//   index and data; ready is always high. Write only while the block is idle.
//   The gain divider resolves one quotient bit per cycle and accepts a new
//   item only once the previous result is taken; power, memory update and
//   multiply stages overlap the division of the previous item.
//   Reset clears counters and restarts the minimum tracker; the noise store
//   reads as zero for bins not yet visited, with no clearing pass.
//   When the receiver stalls, the result holds in the output register, the
//   next item completes its division and waits, and the input stalls once
//   the stages in front of the divider are full.
// ----------------------------------------------------------------------------
module spectral_subtraction_gain
  import ssg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input bins
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  bin_real_i,
  input  logic signed [SampleW-1:0]  bin_imag_i,
  // Results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [GainW-1:0]           bin_gain_o,
  output logic [PowerW-1:0]          noise_level_o,
  output logic [BinW-1:0]            bin_number_o,
  output logic                       frame_end_o,
  // Configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  // Configuration registers
  logic [FrameBinW-1:0] frame_bins_q;
  logic [FactorW-1:0]   over_sub_q;
  logic [FactorW-1:0]   gain_floor_q;
  logic [WindowW-1:0]   window_q;

  // Frame counters
  logic [BinW-1:0]      bin_cnt_q, bin_cnt_d;
  logic [WindowW-1:0]   frame_cnt_q, frame_cnt_d;
  logic                 restart_q, restart_d;
  logic [CntW-1:0]      frame_len;
  logic [CntW-1:0]      bin_next;
  logic [WindowW:0]     frame_inc;
  logic                 is_last;

  // Pipeline control
  logic accept, s1_go, s2_go, s3_go;
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s2_free, s3_free, div_free, out_free, out_take, div_take;
  logic div_busy, div_done;

  // Power
  logic signed [2*SampleW-1:0] re_sq, im_sq;
  logic [2*SampleW-1:0]        pow_sum;
  ssg_item_t                   item;

  // Stage registers
  ssg_upd_t          upd, s2_q, s3_q;
  logic [ProdW-1:0]  prod_q;
  logic [ProdW-QShift-1:0] sub;
  logic [ProdW-QShift-1:0] pow_ext;
  logic [PowerW-1:0] num_diff, num;
  ssg_div_req_t      div_req;
  ssg_div_rsp_t      div_rsp;

  // Output register
  logic              out_valid_q;
  ssg_div_rsp_t      out_q;

  // Item tracking for checks
  logic [2:0]        inflight_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bins_q <= FrameBinsRst;
      over_sub_q   <= OverSubRst;
      gain_floor_q <= FloorRst;
      window_q     <= WindowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgFrameBins: frame_bins_q <= cfg_data_i[FrameBinW-1:0];
        CfgOverSub:   over_sub_q   <= cfg_data_i[FactorW-1:0];
        CfgGainFloor: gain_floor_q <= cfg_data_i[FactorW-1:0];
        CfgWindow:    window_q     <= cfg_data_i[WindowW-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and stage advance
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_take   = out_valid_q && !out_stall_i;
  assign div_take   = div_done && out_free;
  assign div_free   = !div_busy || div_take;
  assign s3_free    = !s3_valid_q || div_free;
  assign s3_go      = s3_valid_q && div_free;
  assign s2_free    = !s2_valid_q || s3_free;
  assign s2_go      = s2_valid_q && s3_free;
  assign s1_go      = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_go) begin
        s3_valid_q <= 1'b1;
      end else if (s3_go) begin
        s3_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Bin and frame counting
  // ---------------------------------------------------------------------------
  always_comb begin
    if (frame_bins_q == '0) begin
      frame_len = CntW'(1);
    end else if (int'(frame_bins_q) > MaxBins) begin
      frame_len = CntW'(MaxBins);
    end else begin
      frame_len = CntW'(frame_bins_q);
    end
    bin_next  = {1'b0, bin_cnt_q} + CntW'(1);
    is_last   = (bin_next >= frame_len);
    frame_inc = {1'b0, frame_cnt_q} + (WindowW+1)'(1);

    bin_cnt_d   = bin_cnt_q;
    frame_cnt_d = frame_cnt_q;
    restart_d   = restart_q;
    if (accept) begin
      if (is_last) begin
        bin_cnt_d = '0;
        if (frame_inc >= {1'b0, window_q}) begin
          frame_cnt_d = '0;
          restart_d   = 1'b1;
        end else begin
          frame_cnt_d = frame_inc[WindowW-1:0];
          restart_d   = 1'b0;
        end
      end else begin
        bin_cnt_d = bin_next[BinW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q   <= '0;
      frame_cnt_q <= '0;
      restart_q   <= 1'b1;
    end else begin
      bin_cnt_q   <= bin_cnt_d;
      frame_cnt_q <= frame_cnt_d;
      restart_q   <= restart_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Bin power, saturated to the field range
  // ---------------------------------------------------------------------------
  always_comb begin
    re_sq   = bin_real_i * bin_real_i;
    im_sq   = bin_imag_i * bin_imag_i;
    pow_sum = $unsigned(re_sq) + $unsigned(im_sq);
    item.idx     = bin_cnt_q;
    item.last    = is_last;
    item.restart = restart_q;
    item.power   = pow_sum[PowerW] ? PowerMax : pow_sum[PowerW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Minimum and noise update in the bin store
  // ---------------------------------------------------------------------------
  ssg_bin_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (accept),
    .item_i (item),
    .adv_i  (s1_go),
    .upd_o  (upd)
  );

  // ---------------------------------------------------------------------------
  // Over-subtraction product
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_q <= upd;
    end
    if (s2_go) begin
      s3_q   <= s2_q;
      prod_q <= ProdW'(over_sub_q) * ProdW'(s2_q.noise);
    end
  end

  // ---------------------------------------------------------------------------
  // Numerator with floor clamp, then divide by power plus one
  // ---------------------------------------------------------------------------
  always_comb begin
    sub      = prod_q[ProdW-1:QShift];
    pow_ext  = (ProdW-QShift)'(s3_q.power);
    num_diff = (pow_ext > sub) ? s3_q.power - sub[PowerW-1:0] : '0;
    num      = (num_diff < PowerW'(gain_floor_q)) ? PowerW'(gain_floor_q) : num_diff;

    div_req.num   = num;
    div_req.den   = {1'b0, s3_q.power} + (PowerW+1)'(1);
    div_req.zero  = !(s3_q.power > PowerW'(gain_floor_q));
    div_req.noise = s3_q.noise;
    div_req.idx   = s3_q.idx;
    div_req.last  = s3_q.last;
  end

  ssg_gain_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s3_go),
    .req_i  (div_req),
    .take_i (div_take),
    .busy_o (div_busy),
    .done_o (div_done),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_take) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      out_q <= div_rsp;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_gain_o    = out_q.gain;
  assign noise_level_o = out_q.noise;
  assign bin_number_o  = out_q.idx;
  assign frame_end_o   = out_q.last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Count items between input and output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(accept) - 3'(out_take);
    end
  end

  // Every accepted item sits in exactly one stage
  a_item_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'($countones({s1_valid_q, s2_valid_q, s3_valid_q,
                                 div_busy, out_valid_q})))
    else $error("item count does not match stage occupancy");

  // The memory stage is never overwritten before it writes back
  a_s1_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!s1_valid_q || s1_go))
    else $error("memory stage overwritten");

  // A finished quotient waits while the output register is held
  a_div_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done && !out_free) |=> (div_done && $stable(div_rsp)))
    else $error("divider result lost under stall");

endmodule

>>> dv/tb_spectral_subtraction_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectral_subtraction_gain
// Self-checking bench for the spectral subtraction gain block. FFT bins are
// fed through the input channel while the bench keeps its own copy of the
// per-bin minimum and noise stores and the frame counters. Each result is
// checked field by field against the predicted gain, noise level, bin number
// and frame end. Directed tests cover sample extremes, frame and window
// length corner cases and gain register extremes. Random phases with random
// register settings, sender gaps and receiver stalls follow, then a steady stream.
// ----------------------------------------------------------------------------
module tb_spectral_subtraction_gain
  import ssg_pkg::*;
();

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 20;

  // One predicted result
  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [PowerW-1:0] noise;
    logic [BinW-1:0]   bin_no;
    logic              frame_end;
  } bin_result_t;

  // DUT signals
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] bin_real_i  = '0;
  logic signed [SampleW-1:0] bin_imag_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [GainW-1:0]          bin_gain_o;
  logic [PowerW-1:0]         noise_level_o;
  logic [BinW-1:0]           bin_number_o;
  logic                      frame_end_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_data_i  = '0;

  // Bench control
  bin_result_t gain_results_q[$];
  int          err_cnt       = 0;
  int          cycle_cnt     = 0;
  int          stall_left    = 0;
  logic        in_gaps_on    = 1'b1;
  logic        out_stalls_on = 1'b1;

  // Model copy of the block state and registers
  logic [PowerW-1:0]    min_power_mem [MaxBins];
  logic [PowerW-1:0]    noise_mem [MaxBins];
  int unsigned          bin_cnt;
  int unsigned          frame_cnt;
  logic                 restart_pending;
  logic [FrameBinW-1:0] cfg_frame_bins;
  logic [FactorW-1:0]   cfg_over_sub;
  logic [FactorW-1:0]   cfg_floor;
  logic [WindowW-1:0]   cfg_window;

  spectral_subtraction_gain u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .bin_real_i   (bin_real_i),
    .bin_imag_i   (bin_imag_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bin_gain_o   (bin_gain_o),
    .noise_level_o(noise_level_o),
    .bin_number_o (bin_number_o),
    .frame_end_o  (frame_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_spectral_subtraction_gain NOT OK");
      $finish;
    end
  end

  // Stall the receiver in random bursts
  always @(negedge clk_i) begin
    if (!out_stalls_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    bin_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gain_results_q.size() == 0) begin
        $display("%0t: result with nothing pending: bin %0d gain %0d", $time,
                 bin_number_o, bin_gain_o);
        err_cnt++;
      end else begin
        want = gain_results_q.pop_front();
        if (bin_gain_o !== want.gain) begin
          $display("%0t: bin_gain expected %0d actual %0d", $time, want.gain, bin_gain_o);
          err_cnt++;
        end
        if (noise_level_o !== want.noise) begin
          $display("%0t: noise_level expected %0d actual %0d", $time, want.noise,
                   noise_level_o);
          err_cnt++;
        end
        if (bin_number_o !== want.bin_no) begin
          $display("%0t: bin_number expected %0d actual %0d", $time, want.bin_no,
                   bin_number_o);
          err_cnt++;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end,
                   frame_end_o);
          err_cnt++;
        end
      end
    end
  end

  // Advance the model by one bin and return the result it gives
  function automatic bin_result_t predict_gain(logic signed [SampleW-1:0] re,
                                               logic signed [SampleW-1:0] im);
    longint            sq;
    longint unsigned   mean_pow;
    longint unsigned   upd;
    longint unsigned   sub;
    longint unsigned   num;
    longint unsigned   quo;
    logic [PowerW-1:0] power;
    logic [PowerW-1:0] noise;
    int unsigned       len;
    bin_result_t       r;
    sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    power = (sq > longint'(PowerMax)) ? PowerMax : sq[PowerW-1:0];

    // Track the minimum; a restart frame takes the power as it is
    if (restart_pending || power < min_power_mem[bin_cnt]) begin
      min_power_mem[bin_cnt] = power;
    end

    // Move the noise one eighth toward the mean of minimum and old noise
    noise = noise_mem[bin_cnt];
    mean_pow = (64'(min_power_mem[bin_cnt]) + 64'(noise)) >> MeanShift;
    upd = 64'(noise) - 64'(noise >> SmoothSh) + (mean_pow >> SmoothSh);
    noise = upd[PowerW-1:0];
    noise_mem[bin_cnt] = noise;

    // Subtract the scaled noise, clamp at the floor, divide by power + 1
    r.gain = '0;
    if (power > cfg_floor) begin
      sub = (64'(cfg_over_sub) * 64'(noise)) >> QShift;
      num = (64'(power) > sub) ? 64'(power) - sub : 64'd0;
      if (num < 64'(cfg_floor)) begin
        num = 64'(cfg_floor);
      end
      quo = (num << QShift) / (64'(power) + 64'd1);
      r.gain = quo[GainW-1:0];
    end

    // Zero bins act as one, oversize frames as the store depth
    if (cfg_frame_bins == 0) begin
      len = 1;
    end else if (cfg_frame_bins > MaxBins) begin
      len = MaxBins;
    end else begin
      len = cfg_frame_bins;
    end
    r.noise     = noise;
    r.bin_no    = bin_cnt[BinW-1:0];
    r.frame_end = (bin_cnt + 1 >= len);

    if (r.frame_end) begin
      bin_cnt = 0;
      restart_pending = 1'b0;
      frame_cnt++;
      if (frame_cnt >= cfg_window) begin
        frame_cnt = 0;
        restart_pending = 1'b1;
      end
      frame_cnt &= 32'hFFFF;
    end else begin
      bin_cnt++;
    end
    return r;
  endfunction

  // Pick one bin: mostly full range or small noise, sometimes extremes
  function automatic logic [2*SampleW-1:0] random_bin();
    logic [SampleW-1:0] v [2];
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: v[i] = SampleW'($urandom);
        5, 6, 7:       v[i] = SampleW'($urandom_range(0, 127)) - 16'd64;
        8:             v[i] = SampleW'($urandom_range(0, 4000)) - 16'd2000;
        default: begin
          case ($urandom_range(0, 5))
            0:       v[i] = 16'h8000;
            1:       v[i] = 16'h8001;
            2:       v[i] = 16'hFFFF;
            3:       v[i] = 16'h0000;
            4:       v[i] = 16'h0001;
            default: v[i] = 16'h7FFF;
          endcase
        end
      endcase
    end
    return {v[0], v[1]};
  endfunction

  // Transfer one bin, with an optional sender gap in front
  task automatic send_bin(input logic signed [SampleW-1:0] re,
                          input logic signed [SampleW-1:0] im);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_real_i <= re;
    bin_imag_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    gain_results_q.push_back(predict_gain(re, im));
    @(negedge clk_i);
  endtask

  task automatic send_random_bins(input int count);
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
    repeat (count) begin
      {re, im} = random_bin();
      send_bin(re, im);
    end
  endtask

  // Drop valid and hold until every pending result has arrived
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (gain_results_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one register; call only while the block is idle
  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFrameBins: cfg_frame_bins = data[FrameBinW-1:0];
      CfgOverSub:   cfg_over_sub   = data[FactorW-1:0];
      CfgGainFloor: cfg_floor      = data[FactorW-1:0];
      CfgWindow:    cfg_window     = data[WindowW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Oversize frame acts as 512 bins; the restart frame after reset writes
  // every minimum entry, so later frame sizes never read an unwritten one
  task automatic test_frame_cap();
    write_register(CfgFrameBins, 16'hFFFF);
    send_random_bins(MaxBins);
    wait_idle();
  endtask

  // Sample extremes, including the power overflow of two -32768 parts
  task automatic test_sample_extremes();
    write_register(CfgFrameBins, 16'd8);
    send_bin(16'sh0000, 16'sh0000);
    send_bin(16'sh7FFF, 16'sh7FFF);
    send_bin(16'sh8001, 16'sh8001);
    send_bin(16'sh8000, 16'sh8000);
    send_bin(16'sh8000, 16'sh7FFF);
    send_bin(16'sh7FFF, 16'sh8000);
    send_bin(16'shFFFF, 16'shFFFF);
    send_bin(16'sh0001, 16'shFFFF);
    wait_idle();
  endtask

  // Zero frame length, then a frame cut short by a lowered length
  task automatic test_frame_length();
    write_register(CfgFrameBins, 16'd0);
    send_random_bins(2);
    wait_idle();
    write_register(CfgFrameBins, 16'd6);
    send_random_bins(5);
    wait_idle();
    // current bin is past the new last bin, so the frame ends here
    write_register(CfgFrameBins, 16'd2);
    send_random_bins(3);
    wait_idle();
  endtask

  // Zero window, widest window, then a window lowered below the count
  task automatic test_window_length();
    write_register(CfgWindow, 16'd0);
    send_random_bins(4);
    wait_idle();
    write_register(CfgWindow, 16'hFFFF);
    write_register(CfgFrameBins, 16'd1);
    send_random_bins(6);
    wait_idle();
    write_register(CfgWindow, 16'd3);
    send_random_bins(3);
    wait_idle();
  endtask

  // Over-subtraction and floor at their extremes
  task automatic test_gain_settings();
    write_register(CfgFrameBins, 16'd4);
    write_register(CfgWindow, 16'd20);
    write_register(CfgOverSub, 16'd0);
    send_random_bins(3);
    wait_idle();
    write_register(CfgOverSub, 16'hFFFF);
    send_random_bins(3);
    wait_idle();
    // powers just below and just above the top floor
    write_register(CfgGainFloor, 16'hFFFF);
    send_bin(16'sd181, 16'sd0);
    send_bin(16'sd182, 16'sd0);
    send_bin(16'sd0, -16'sd182);
    wait_idle();
  endtask

  // Random register settings, traffic and idling, phase by phase
  task automatic test_random_traffic(input int phases);
    logic [CfgDataW-1:0] val;
    repeat (phases) begin
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:       val = 16'd0;
          1:       val = 16'd1023;
          2:       val = 16'd512;
          default: val = 16'($urandom_range(1, 16));
        endcase
        write_register(CfgFrameBins, {6'($urandom), val[FrameBinW-1:0]});
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       val = 16'd0;
          1:       val = 16'd32767;
          default: val = 16'($urandom_range(0, 2048));
        endcase
        write_register(CfgOverSub, {1'($urandom), val[FactorW-1:0]});
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       val = 16'd0;
          1:       val = 16'd32767;
          default: val = 16'($urandom_range(0, 4096));
        endcase
        write_register(CfgGainFloor, {1'($urandom), val[FactorW-1:0]});
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       val = 16'd0;
          1:       val = 16'd65535;
          default: val = 16'($urandom_range(1, 6));
        endcase
        write_register(CfgWindow, val);
      end
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      send_random_bins($urandom_range(10, 30));
    end
    wait_idle();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    write_register(CfgFrameBins, 16'd5);
    write_register(CfgOverSub, 16'd512);
    write_register(CfgGainFloor, 16'd0);
    write_register(CfgWindow, 16'd4);
    send_random_bins(40);
    wait_idle();
  endtask

  initial begin
    // Model state after reset
    for (int i = 0; i < MaxBins; i++) begin
      min_power_mem[i] = '0;
      noise_mem[i]     = '0;
    end
    bin_cnt         = 0;
    frame_cnt       = 0;
    restart_pending = 1'b1;
    cfg_frame_bins  = FrameBinsRst;
    cfg_over_sub    = OverSubRst;
    cfg_floor       = FloorRst;
    cfg_window      = WindowRst;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_frame_cap();
    test_sample_extremes();
    test_frame_length();
    test_window_length();
    test_gain_settings();
    test_random_traffic(8);
    test_steady_stream();

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && gain_results_q.size() == 0) begin
      $display("tb_spectral_subtraction_gain OK");
    end else begin
      $display("tb_spectral_subtraction_gain NOT OK");
    end
    $finish;
  end

endmodule

>>> spectral_subtraction_gain.f
design/ssg_pkg.sv
design/ssg_bin_store.sv
design/ssg_gain_div.sv
design/spectral_subtraction_gain.sv
dv/tb_spectral_subtraction_gain.sv
